/* hw/rtl/ffd_pkg.sv */
// Shared types, codes and helpers for the flagged frame deframer.
// No dependencies; every other file of the block imports this package.
package ffd_pkg;

    // Frame constants
    localparam logic [7:0] MAGIC_BYTE   = 8'hFF;
    localparam logic [1:0] FLAG_VERSION = 2'd1;
    localparam int         FLAG_RSVD    = 0;

    // Presence bit positions inside the stored 5-bit presence field
    localparam int PRES_DEVICE = 4;
    localparam int PRES_CMD    = 3;
    localparam int PRES_SER    = 2;
    localparam int PRES_LEN    = 1;
    localparam int PRES_CHECK  = 0;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_MAGIC  = 4'd0,
        PH_FLAGS  = 4'd1,
        PH_DEVICE = 4'd2,
        PH_CMD    = 4'd3,
        PH_SER    = 4'd4,
        PH_LEN    = 4'd5,
        PH_PAY    = 4'd6,
        PH_CKH    = 4'd7,
        PH_CKL    = 4'd8,
        PH_DRAIN  = 4'd9,
        PH_END    = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_VERSION   = 3'd3,
        ST_RESERVED  = 3'd4,
        ST_CHECKSUM  = 3'd5,
        ST_TOO_LONG  = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [31:0] frame_device;
        logic [14:0] frame_command;
        logic [14:0] frame_serial;
        logic [14:0] frame_payload_len;
    } t_result;

    // Up to two result words per byte, payload word first
    typedef struct packed {
        logic    pay_v;
        logic    sum_v;
        t_result pay;
        t_result sum;
    } t_push;

    // First section after 'from' that this frame carries, or PH_END
    function automatic t_phase follow_phase(input t_phase from, input logic [4:0] pres,
                                            input logic len_nz);
        logic [15:0] avail;
        t_phase      res;
        avail            = '0;
        avail[PH_DEVICE] = pres[PRES_DEVICE];
        avail[PH_CMD]    = pres[PRES_CMD];
        avail[PH_SER]    = pres[PRES_SER];
        avail[PH_LEN]    = pres[PRES_LEN];
        avail[PH_PAY]    = len_nz;
        avail[PH_CKH]    = pres[PRES_CHECK];
        res              = PH_END;
        for (int p = int'(PH_CKH); p >= int'(PH_DEVICE); p--) begin
            if ((p > int'(from)) && avail[4'(p)]) begin
                res = t_phase'(4'(p));
            end
        end
        return res;
    endfunction

endpackage

/* hw/rtl/ffd_if.sv */
// Handshake channels of the deframer: raw byte input and result output.
// Depends on ffd_pkg for field widths.
interface ffd_byte_if;
    import ffd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ffd_result_if;
    import ffd_pkg::*;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [31:0] frame_device;
    logic [14:0] frame_command;
    logic [14:0] frame_serial;
    logic [14:0] frame_payload_len;
    modport source (output valid, kind, payload_byte, status, frame_device, frame_command,
                    frame_serial, frame_payload_len, input ready);
    modport sink   (input valid, kind, payload_byte, status, frame_device, frame_command,
                    frame_serial, frame_payload_len, output ready);
endinterface

/* hw/rtl/ffd_in_stage.sv */
// Input register of the deframer: holds one byte word until the parser takes it.
// Depends on ffd_pkg.
module ffd_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ffd_pkg::t_in_word i_word,
    output logic             o_ready,
    input  logic             i_take,
    output logic             o_valid,
    output ffd_pkg::t_in_word o_word
);
    import ffd_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // Accept when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload on accept
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

/* hw/rtl/ffd_parser.sv */
// Frame parser: phase machine, field accumulators and running checksum.
// Emits a payload word and/or a summary word per byte. Depends on ffd_pkg.
module ffd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  ffd_pkg::t_in_word i_word,
    output ffd_pkg::t_push    o_push
);
    import ffd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pres, n_pres;
    logic [31:0] r_dev, n_dev;
    logic [14:0] r_cmd, n_cmd;
    logic [14:0] r_ser, n_ser;
    logic [14:0] r_len, n_len;
    logic [14:0] r_bl, n_bl;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_chk_hi, n_chk_hi;
    t_status     r_err, n_err;

    logic        done;
    logic        frame_end;
    logic [14:0] cur_var;
    logic [14:0] var_val;
    t_phase      nxt;
    logic [7:0]  b;
    logic        last;

    assign b    = i_word.data_byte;
    assign last = i_word.last_byte;

    // Varint register of the current section
    always_comb begin
        case (r_phase)
            PH_CMD:  cur_var = r_cmd;
            PH_SER:  cur_var = r_ser;
            default: cur_var = r_len;
        endcase
    end

    // Next state and result words
    always_comb begin
        n_phase   = r_phase;
        n_pres    = r_pres;
        n_dev     = r_dev;
        n_cmd     = r_cmd;
        n_ser     = r_ser;
        n_len     = r_len;
        n_bl      = r_bl;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_chk_hi  = r_chk_hi;
        n_err     = r_err;
        done      = 1'b0;
        frame_end = 1'b0;
        var_val   = '0;
        nxt       = r_phase;
        o_push    = '0;

        if (i_take) begin
            // Running checksum covers every byte before the checksum itself
            if (r_phase < PH_CKH) begin
                n_sum = r_sum + {8'd0, b};
            end

            case (r_phase)
                PH_MAGIC: begin
                    if (b != MAGIC_BYTE) begin
                        n_err = ST_MAGIC;
                        nxt   = PH_DRAIN;
                    end else begin
                        nxt = PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    if (b[7:6] != FLAG_VERSION) begin
                        n_err = ST_VERSION;
                        nxt   = PH_DRAIN;
                    end else if (b[FLAG_RSVD]) begin
                        n_err = ST_RESERVED;
                        nxt   = PH_DRAIN;
                    end else begin
                        n_pres = b[5:1];
                        done   = 1'b1;
                    end
                end
                PH_DEVICE: begin
                    n_dev = {r_dev[23:0], b};
                    if (r_cnt == 2'd3) begin
                        done = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
                PH_CMD, PH_SER, PH_LEN: begin
                    if (r_cnt == 2'd0) begin
                        var_val = {8'd0, b[6:0]};
                        if (b[7]) begin
                            n_cnt = 2'd1;
                        end else begin
                            done = 1'b1;
                        end
                    end else begin
                        var_val = {b, cur_var[6:0]};
                        done    = 1'b1;
                    end
                    if (r_phase == PH_CMD) begin
                        n_cmd = var_val;
                    end else if (r_phase == PH_SER) begin
                        n_ser = var_val;
                    end else begin
                        n_len = var_val;
                        if (done) begin
                            n_bl = var_val;
                        end
                    end
                end
                PH_PAY: begin
                    o_push.pay_v              = 1'b1;
                    o_push.pay.kind           = KIND_PAYLOAD;
                    o_push.pay.payload_byte   = b;
                    o_push.pay.status         = ST_OK;
                    n_bl                      = r_bl - 15'd1;
                    if (n_bl == 15'd0) begin
                        done = 1'b1;
                    end
                end
                PH_CKH: begin
                    n_chk_hi = b;
                    nxt      = PH_CKL;
                end
                PH_CKL: begin
                    if ({r_chk_hi, b} != r_sum) begin
                        n_err = ST_CHECKSUM;
                    end
                    nxt = PH_END;
                end
                default: begin
                    nxt = PH_DRAIN;
                end
            endcase

            // Advance to the next section present in this frame
            if (done) begin
                n_cnt = 2'd0;
                nxt   = follow_phase(r_phase, n_pres, n_len != 15'd0);
            end
            if (nxt == PH_END) begin
                frame_end = 1'b1;
                if (n_err == ST_OK && !last) begin
                    n_err = ST_TOO_LONG;
                end
                nxt = PH_DRAIN;
            end
            // First error wins: drop bytes until the buffer ends
            if (n_err != ST_OK) begin
                nxt = PH_DRAIN;
            end
            n_phase = nxt;

            // Close the buffer: emit the summary and clear all state
            if (last) begin
                if (n_err == ST_OK && !frame_end) begin
                    n_err = ST_SHORT;
                end
                o_push.sum_v       = 1'b1;
                o_push.sum.kind    = KIND_SUMMARY;
                o_push.sum.status  = n_err;
                if (n_err == ST_OK) begin
                    o_push.sum.frame_device      = n_dev;
                    o_push.sum.frame_command     = n_cmd;
                    o_push.sum.frame_serial      = n_ser;
                    o_push.sum.frame_payload_len = n_len;
                end
                n_phase  = PH_MAGIC;
                n_pres   = '0;
                n_dev    = '0;
                n_cmd    = '0;
                n_ser    = '0;
                n_len    = '0;
                n_bl     = '0;
                n_cnt    = '0;
                n_sum    = '0;
                n_chk_hi = '0;
                n_err    = ST_OK;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_pres   <= '0;
            r_dev    <= '0;
            r_cmd    <= '0;
            r_ser    <= '0;
            r_len    <= '0;
            r_bl     <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_chk_hi <= '0;
            r_err    <= ST_OK;
        end else begin
            r_phase  <= n_phase;
            r_pres   <= n_pres;
            r_dev    <= n_dev;
            r_cmd    <= n_cmd;
            r_ser    <= n_ser;
            r_len    <= n_len;
            r_bl     <= n_bl;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_chk_hi <= n_chk_hi;
            r_err    <= n_err;
        end
    end

`ifndef NO_ASSERTIONS
    // A summary always leaves the parser ready for a fresh magic byte
    a_sum_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.sum_v |=> (r_phase == PH_MAGIC && r_err == ST_OK && r_sum == 16'd0))
        else $error("parser state not cleared after summary");

    // Payload words come only from the payload section
    a_pay_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.pay_v |-> (r_phase == PH_PAY && r_bl != 15'd0))
        else $error("payload word outside payload section");

    // Draining implies a latched error
    a_drain_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DRAIN) |-> (r_err != ST_OK))
        else $error("drain phase without error");
`endif

endmodule

/* hw/rtl/ffd_out_fifo.sv */
// Result queue: takes up to two words per cycle in order, gives one per cycle while i_ready is high.
// Depends on ffd_pkg.
module ffd_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ffd_pkg::t_push   i_push,
    output logic             o_space,
    output logic             o_valid,
    output ffd_pkg::t_result o_data,
    input  logic             i_ready
);
    import ffd_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic [FIFO_AW-1:0]   wr_ptr1;
    logic [FIFO_AW-1:0]   sum_ptr;
    logic [1:0]           push_n;
    logic                 pop;

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_space = r_count <= FIFO_CW'(FIFO_DEPTH - 2);
    assign pop     = o_valid && i_ready;

    assign wr_ptr1  = r_wr_ptr + FIFO_AW'(1);
    assign sum_ptr  = i_push.pay_v ? wr_ptr1 : r_wr_ptr;
    assign push_n   = {1'b0, i_push.pay_v} + {1'b0, i_push.sum_v};
    assign n_wr_ptr = r_wr_ptr + FIFO_AW'(push_n);
    assign n_rd_ptr = r_rd_ptr + FIFO_AW'(pop);
    assign n_count  = r_count + FIFO_CW'(push_n) - FIFO_CW'(pop);

    // Write payload word first, summary behind it
    always_ff @(posedge i_clk) begin
        if (i_push.pay_v) begin
            r_mem[r_wr_ptr] <= i_push.pay;
        end
        if (i_push.sum_v) begin
            r_mem[sum_ptr] <= i_push.sum;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    // Pushes happen only with room for two words
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.pay_v || i_push.sum_v) |-> o_space)
        else $error("push into queue without room");

    // Fill count never exceeds depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue overflow");
`endif

endmodule

/* hw/rtl/flagged_frame_deframer_core.sv */
// Top level of the flagged frame deframer: input register, parser, result queue.
// Depends on ffd_pkg, ffd_if, ffd_in_stage, ffd_parser and ffd_out_fifo.
//
//   channel    dir  word contents
//   i_byte     in   data_byte[7:0], last_byte
//   o_result   out  kind, payload_byte, status, frame_device, frame_command,
//                   frame_serial, frame_payload_len
//
// One byte word is accepted per cycle while i_byte.ready is high; the parser handles it from the input register.
// Each byte gives zero, one or two result words (payload then summary) into a
// four-word queue; each result word becomes valid once the queue has registered it.
// The parser takes a held byte only while the queue has two free slots, so a stalled
// output drops i_byte.ready once three or four words are queued and one byte is held.
// i_rst_n is synchronous, active low, and clears all frame state and the queue.
module flagged_frame_deframer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ffd_byte_if.sink            i_byte,
    ffd_result_if.source        o_result
);
    import ffd_pkg::*;

    t_in_word in_word;
    t_in_word held_word;
    logic     held_valid;
    logic     in_ready;
    logic     take;
    logic     space;
    t_push    push;
    t_result  head;

    assign in_word.data_byte = i_byte.data_byte;
    assign in_word.last_byte = i_byte.last_byte;
    assign i_byte.ready      = in_ready;

    // Hand the held byte to the parser when the queue can take its results
    assign take = held_valid && space;

    ffd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte.valid),
        .i_word  (in_word),
        .o_ready (in_ready),
        .i_take  (take),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    ffd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_word  (held_word),
        .o_push  (push)
    );

    ffd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_result.valid),
        .o_data  (head),
        .i_ready (o_result.ready)
    );

    // Drive the result channel from the queue head
    assign o_result.kind              = head.kind;
    assign o_result.payload_byte      = head.payload_byte;
    assign o_result.status            = head.status;
    assign o_result.frame_device      = head.frame_device;
    assign o_result.frame_command     = head.frame_command;
    assign o_result.frame_serial      = head.frame_serial;
    assign o_result.frame_payload_len = head.frame_payload_len;

endmodule

/* tb/flagged_frame_deframer_core_test.sv */
// Self-checking testbench for flagged_frame_deframer_core: directed frames, then random frames.
// Depends on ffd_pkg, on ffd_byte_if / ffd_result_if and on the deframer RTL.
module flagged_frame_deframer_core_test;
    import ffd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pinned;
        t_status    status;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    ffd_byte_if   byte_ch ();
    ffd_result_if result_ch ();

    // Status pinned by the directed rows, carried along with each byte word
    logic    row_pinned;
    t_status row_pinned_status;

    // Deframer state as the checker tracks it
    t_phase      ph;
    logic [4:0]  pres;
    logic [31:0] dev_acc;
    logic [14:0] cmd_val;
    logic [14:0] ser_val;
    logic [14:0] len_val;
    logic [14:0] pay_left;
    logic [1:0]  fld_cnt;
    logic [15:0] run_sum;
    logic [7:0]  ck_hi;
    t_status     err_code;
    t_result     step_words [2];

    t_result     results_due [$];
    logic [7:0]  frame_q [$];

    int unsigned fail_count    = 0;
    int unsigned live_bytes    = 0;
    int unsigned payload_words = 0;
    int unsigned summary_words = 0;
    int unsigned frames_sent   = 0;
    int unsigned status_seen [7];
    int unsigned tx_mode       = 0;
    int unsigned rx_mode       = 0;
    int unsigned rx_mode_left  = 0;
    int unsigned rx_hold       = 0;

    // Directed frames; a pinned row must give one summary with zero fields
    t_row dir_rows [0:28] = '{
        // magic alone, then a wrong magic
        '{8'hFF, 1'b1, 1'b1, ST_SHORT},
        '{8'h00, 1'b1, 1'b1, ST_MAGIC},
        // bare frame with no sections
        '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h40, 1'b1, 1'b1, ST_OK},
        // wrong version, then reserved bit set
        '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hC0, 1'b1, 1'b1, ST_VERSION},
        '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h41, 1'b1, 1'b1, ST_RESERVED},
        // complete frame followed by a stray byte
        '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h40, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b1, 1'b1, ST_TOO_LONG},
        // every section: device, two-byte command of all ones, serial 0, two payload bytes
        '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h7E, 1'b0, 1'b0, ST_OK},
        '{8'hDE, 1'b0, 1'b0, ST_OK}, '{8'hAD, 1'b0, 1'b0, ST_OK},
        '{8'hBE, 1'b0, 1'b0, ST_OK}, '{8'hEF, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h02, 1'b0, 1'b0, ST_OK},
        '{8'hAB, 1'b0, 1'b0, ST_OK}, '{8'h80, 1'b0, 1'b0, ST_OK},
        '{8'h07, 1'b0, 1'b0, ST_OK}, '{8'hE0, 1'b1, 1'b0, ST_OK},
        // checksum only, with a wrong value
        '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h42, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b1, ST_CHECKSUM}
    };

    flagged_frame_deframer_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Return the frame state to its idle values
    function automatic void clear_frame();
        ph       = PH_MAGIC;
        pres     = '0;
        dev_acc  = '0;
        cmd_val  = '0;
        ser_val  = '0;
        len_val  = '0;
        pay_left = '0;
        fld_cnt  = '0;
        run_sum  = '0;
        ck_hi    = '0;
        err_code = ST_OK;
    endfunction

    // First section after 'from' that this frame carries
    function automatic t_phase next_section(input t_phase from);
        t_phase p;
        for (int i = int'(from) + 1; i <= int'(PH_CKH); i++) begin
            p = t_phase'(i);
            case (p)
                PH_DEVICE: if (pres[PRES_DEVICE]) return p;
                PH_CMD:    if (pres[PRES_CMD]) return p;
                PH_SER:    if (pres[PRES_SER]) return p;
                PH_LEN:    if (pres[PRES_LEN]) return p;
                PH_PAY:    if (len_val != 0) return p;
                PH_CKH:    if (pres[PRES_CHECK]) return p;
                default: ;
            endcase
        end
        return PH_END;
    endfunction

    // Advance the frame state by one byte; result words go to step_words
    function automatic int parse_byte(input logic [7:0] b, input logic last);
        t_phase      nxt;
        logic        fin;
        logic [14:0] vint;
        int          n;
        nxt  = ph;
        fin  = 1'b0;
        vint = '0;
        n    = 0;
        if (ph < PH_CKH) begin
            run_sum = run_sum + 16'(b);
        end
        case (ph)
            PH_MAGIC: begin
                if (b != MAGIC_BYTE) begin
                    err_code = ST_MAGIC;
                    nxt      = PH_DRAIN;
                end else begin
                    nxt = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                if (b[7:6] != FLAG_VERSION) begin
                    err_code = ST_VERSION;
                    nxt      = PH_DRAIN;
                end else if (b[0]) begin
                    err_code = ST_RESERVED;
                    nxt      = PH_DRAIN;
                end else begin
                    pres = b[5:1];
                    fin  = 1'b1;
                end
            end
            PH_DEVICE: begin
                dev_acc = {dev_acc[23:0], b};
                if (fld_cnt == 2'd3) fin = 1'b1;
                else fld_cnt = fld_cnt + 2'd1;
            end
            PH_CMD, PH_SER, PH_LEN: begin
                vint = (ph == PH_CMD) ? cmd_val : (ph == PH_SER) ? ser_val : len_val;
                if (fld_cnt == 2'd0) begin
                    vint = {8'd0, b[6:0]};
                    if (b[7]) fld_cnt = 2'd1;
                    else fin = 1'b1;
                end else begin
                    vint = vint | {b, 7'd0};
                    fin  = 1'b1;
                end
                if (ph == PH_CMD) cmd_val = vint;
                else if (ph == PH_SER) ser_val = vint;
                else len_val = vint;
                if (fin && ph == PH_LEN) pay_left = len_val;
            end
            PH_PAY: begin
                step_words[n]              = '0;
                step_words[n].kind         = KIND_PAYLOAD;
                step_words[n].payload_byte = b;
                n++;
                pay_left = pay_left - 15'd1;
                if (pay_left == 0) fin = 1'b1;
            end
            PH_CKH: begin
                ck_hi = b;
                nxt   = PH_CKL;
            end
            PH_CKL: begin
                if ({ck_hi, b} != run_sum) err_code = ST_CHECKSUM;
                nxt = PH_END;
            end
            default: begin
                nxt = PH_DRAIN;
            end
        endcase

        // Close a section, then the frame
        if (fin) begin
            fld_cnt = '0;
            nxt     = next_section(ph);
        end
        if (nxt == PH_END) begin
            if (err_code == ST_OK && !last) err_code = ST_TOO_LONG;
            nxt = PH_DRAIN;
            fin = 1'b1;
        end else begin
            fin = 1'b0;
        end
        if (err_code != ST_OK) nxt = PH_DRAIN;
        ph = nxt;

        // Summary on the buffer's last byte
        if (last) begin
            if (err_code == ST_OK && !fin) err_code = ST_SHORT;
            step_words[n]        = '0;
            step_words[n].kind   = KIND_SUMMARY;
            step_words[n].status = err_code;
            if (err_code == ST_OK) begin
                step_words[n].frame_device      = dev_acc;
                step_words[n].frame_command     = cmd_val;
                step_words[n].frame_serial      = ser_val;
                step_words[n].frame_payload_len = len_val;
            end
            n++;
            clear_frame();
        end
        return n;
    endfunction

    task automatic compare_word(input t_result want, input t_result got);
        if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fail_count++;
        end
        if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
            fail_count++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.frame_device !== want.frame_device) begin
            $error("frame_device: expected %0h, got %0h", want.frame_device, got.frame_device);
            fail_count++;
        end
        if (got.frame_command !== want.frame_command) begin
            $error("frame_command: expected %0h, got %0h",
                   want.frame_command, got.frame_command);
            fail_count++;
        end
        if (got.frame_serial !== want.frame_serial) begin
            $error("frame_serial: expected %0h, got %0h", want.frame_serial, got.frame_serial);
            fail_count++;
        end
        if (got.frame_payload_len !== want.frame_payload_len) begin
            $error("frame_payload_len: expected %0h, got %0h",
                   want.frame_payload_len, got.frame_payload_len);
            fail_count++;
        end
    endtask

    // Check result words and track accepted byte words
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        int      n;
        if (!i_rst_n) begin
            clear_frame();
            results_due.delete();
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got.kind              = result_ch.kind;
                got.payload_byte      = result_ch.payload_byte;
                got.status            = t_status'(result_ch.status);
                got.frame_device      = result_ch.frame_device;
                got.frame_command     = result_ch.frame_command;
                got.frame_serial      = result_ch.frame_serial;
                got.frame_payload_len = result_ch.frame_payload_len;
                if (results_due.size() == 0) begin
                    $error("result word with nothing due: kind %0d status %0d",
                           got.kind, got.status);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    compare_word(want, got);
                    if (want.kind == KIND_SUMMARY) begin
                        summary_words++;
                        status_seen[want.status]++;
                    end else begin
                        payload_words++;
                    end
                end
            end
            if (byte_ch.valid && byte_ch.ready) begin
                if (ph != PH_DRAIN) live_bytes++;
                n = parse_byte(byte_ch.data_byte, byte_ch.last_byte);
                if (row_pinned) begin
                    want        = '0;
                    want.kind   = KIND_SUMMARY;
                    want.status = row_pinned_status;
                    results_due.push_back(want);
                end else begin
                    for (int k = 0; k < n; k++) results_due.push_back(step_words[k]);
                end
            end
        end
    end

    // Output stalls: calm stretches, frequent short stalls, or rare long ones
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(40, 300);
        end else begin
            rx_mode_left--;
        end
        if (rx_hold != 0) begin
            rx_hold--;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
            if (rx_mode == 1 && $urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 3);
            if (rx_mode == 2 && $urandom_range(0, 15) == 0) rx_hold = $urandom_range(8, 40);
        end
    end

    function automatic int unsigned pick_gap();
        if (tx_mode == 1 && $urandom_range(0, 3) == 0) return $urandom_range(1, 2);
        if (tx_mode == 2 && $urandom_range(0, 5) == 0) return $urandom_range(5, 30);
        return 0;
    endfunction

    // Drive one byte word, hold it until the block takes it
    task automatic send_word(input logic [7:0] b, input logic last, input logic pinned,
                             input t_status st);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        row_pinned        <= pinned;
        row_pinned_status <= st;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid and hold off until every due result has come back
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic push_varint(input logic [14:0] v);
        if (v < 15'd128 && $urandom_range(0, 1) == 0) begin
            frame_q.push_back({1'b0, v[6:0]});
        end else begin
            frame_q.push_back({1'b1, v[6:0]});
            frame_q.push_back(v[14:7]);
        end
    endtask

    // Build one random buffer: mostly well-formed frames, some noise and broken ones
    task automatic build_frame();
        logic [7:0]  flags;
        logic [14:0] v;
        logic [15:0] sum;
        logic        big_len;
        int unsigned sel;
        int unsigned npay;
        int unsigned keep;
        frame_q.delete();
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0) frame_q[0] = MAGIC_BYTE;
            return;
        end
        flags      = {FLAG_VERSION, 6'($urandom_range(0, 63))};
        flags[0]   = ($urandom_range(0, 19) == 0);
        if (sel < 18) flags[7:6] = 2'($urandom_range(0, 3));
        big_len    = ($urandom_range(0, 19) == 0);
        frame_q.push_back(MAGIC_BYTE);
        frame_q.push_back(flags);
        if (flags[5]) begin
            repeat (4) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        if (flags[4]) push_varint(15'($urandom));
        if (flags[3]) push_varint(15'($urandom));
        npay = 0;
        if (flags[2]) begin
            if (big_len) v = 15'($urandom_range(100, 32767));
            else if ($urandom_range(0, 5) == 0) v = 15'($urandom_range(13, 48));
            else v = 15'($urandom_range(0, 12));
            push_varint(v);
            npay = big_len ? $urandom_range(0, 8) : v;
        end
        repeat (npay) frame_q.push_back(8'($urandom_range(0, 255)));
        if (flags[1]) begin
            sum = '0;
            foreach (frame_q[k]) sum = sum + 16'(frame_q[k]);
            if ($urandom_range(0, 7) == 0) sum = sum ^ (16'd1 << $urandom_range(0, 15));
            frame_q.push_back(sum[15:8]);
            frame_q.push_back(sum[7:0]);
        end
        // End early or run past the frame now and then
        sel = $urandom_range(0, 9);
        if (sel == 0 && frame_q.size() > 1) begin
            keep = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > keep) void'(frame_q.pop_back());
        end else if (sel == 1) begin
            repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int unsigned random_base;
        logic        paused;
        i_rst_n             <= 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= '0;
        byte_ch.last_byte   <= 1'b0;
        row_pinned          <= 1'b0;
        row_pinned_status   <= ST_OK;
        foreach (status_seen[s]) status_seen[s] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames
        foreach (dir_rows[i]) begin
            tx_mode = $urandom_range(0, 2);
            send_word(dir_rows[i].data, dir_rows[i].last, dir_rows[i].pinned,
                      dir_rows[i].status);
        end
        wait_drained();

        // Random frames, with one full drain half way
        random_base = live_bytes;
        paused      = 1'b0;
        while (live_bytes < random_base + 650) begin
            build_frame();
            tx_mode = ($urandom_range(0, 9) < 3) ? 0 : ($urandom_range(0, 9) < 7) ? 1 : 2;
            foreach (frame_q[k]) begin
                send_word(frame_q[k], k == frame_q.size() - 1, 1'b0, ST_OK);
            end
            frames_sent++;
            if (!paused && live_bytes > random_base + 325) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (12) @(posedge i_clk);
        $display("Ran %0d parsed bytes over %0d random buffers plus the directed frames;",
                 live_bytes, frames_sent);
        $display("checked %0d payload words and %0d summaries,", payload_words, summary_words);
        $display("by status %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog against a hung handshake
    initial begin
        #20000000;
        $display("Timeout with %0d result words still due", results_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
